// ===== hdl/gzhs_pkg.sv =====
package gzhs_pkg;

    localparam logic [7:0] MAGIC_ID1   = 8'h1F;
    localparam logic [7:0] MAGIC_ID2   = 8'h8B;
    localparam logic [7:0] METHOD_DEFL = 8'h08;

    localparam logic [7:0] FL_HCRC     = 8'h02;
    localparam logic [7:0] FL_EXTRA    = 8'h04;
    localparam logic [7:0] FL_NAME     = 8'h08;
    localparam logic [7:0] FL_COMMENT  = 8'h10;
    localparam logic [7:0] FL_RESERVED = 8'hE0;

    localparam int         CNT_W       = 16;
    localparam logic [CNT_W-1:0] FIXED_LEN = 16'd10;
    localparam logic [CNT_W-1:0] CNT_MAX   = 16'hFFFF;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_MAGIC     = 3'd2;
    localparam logic [2:0] ST_RESERVED  = 3'd3;
    localparam logic [2:0] ST_XLEN_TRNC = 3'd4;
    localparam logic [2:0] ST_OVERRUN   = 3'd5;

    typedef struct packed {
        logic [2:0]       status;
        logic [CNT_W-1:0] header_length;
    } gzhs_result_t;

endpackage

// ===== hdl/gzhs_byte_if.sv =====
interface gzhs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

// ===== hdl/gzhs_result_if.sv =====
interface gzhs_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] header_length;

    modport source (output valid, output status, output header_length, input ready);
    modport sink   (input valid, input status, input header_length, output ready);
endinterface

// ===== hdl/gzhs_parse.sv =====
module gzhs_parse
    import gzhs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         take,
    input  logic [7:0]   data_byte,
    input  logic         final_byte,
    output gzhs_result_t result
);

    typedef enum logic [2:0] {
        PH_FIXED,
        PH_XLEN_LO,
        PH_XLEN_HI,
        PH_EXTRA,
        PH_NAME,
        PH_COMMENT,
        PH_HCRC,
        PH_DONE
    } phase_t;

    typedef struct packed {
        phase_t phase;
        logic   load_crc;
        logic   mark_end;
    } adv_t;

    // first pending optional field after 'from'
    function automatic adv_t advance(input phase_t from, input logic [7:0] flags);
        adv_t a;
        a.load_crc = 1'b0;
        a.mark_end = 1'b0;
        if (from < PH_XLEN_LO && (flags & FL_EXTRA) != 8'h00) begin
            a.phase = PH_XLEN_LO;
        end else if (from < PH_NAME && (flags & FL_NAME) != 8'h00) begin
            a.phase = PH_NAME;
        end else if (from < PH_COMMENT && (flags & FL_COMMENT) != 8'h00) begin
            a.phase = PH_COMMENT;
        end else if (from < PH_HCRC && (flags & FL_HCRC) != 8'h00) begin
            a.phase    = PH_HCRC;
            a.load_crc = 1'b1;
        end else begin
            a.phase    = PH_DONE;
            a.mark_end = 1'b1;
        end
        return a;
    endfunction

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       flags_reg, flags_next;
    logic [CNT_W-1:0] skip_reg, skip_next;
    logic [7:0]       xlen_lo_reg, xlen_lo_next;
    logic [CNT_W-1:0] hend_reg, hend_next;
    logic [2:0]       err_reg, err_next;

    logic [CNT_W-1:0] skip_dec;
    logic [2:0]       err_new;
    logic             do_adv;
    phase_t           adv_from;
    adv_t             adv;

    always_comb
    begin
        count_next   = (count_reg == CNT_MAX) ? count_reg : count_reg + 1'b1;
        phase_next   = phase_reg;
        flags_next   = flags_reg;
        skip_next    = skip_reg;
        xlen_lo_next = xlen_lo_reg;
        hend_next    = hend_reg;
        err_new      = ST_OK;
        do_adv       = 1'b0;
        adv_from     = phase_reg;
        skip_dec     = skip_reg - 1'b1;

        case (phase_reg)
            PH_FIXED:
            begin
                if ((count_reg == 16'd0 && data_byte != MAGIC_ID1) ||
                    (count_reg == 16'd1 && data_byte != MAGIC_ID2) ||
                    (count_reg == 16'd2 && data_byte != METHOD_DEFL))
                begin
                    err_new = ST_MAGIC;
                end
                if (count_reg == 16'd3)
                begin
                    flags_next = data_byte;
                    if ((data_byte & FL_RESERVED) != 8'h00)
                    begin
                        err_new = ST_RESERVED;
                    end
                end
                do_adv = (count_reg >= FIXED_LEN - 1'b1);
            end
            PH_XLEN_LO:
            begin
                xlen_lo_next = data_byte;
                phase_next   = PH_XLEN_HI;
            end
            PH_XLEN_HI:
            begin
                skip_next = {data_byte, xlen_lo_reg};
                adv_from  = PH_EXTRA;
                if ({data_byte, xlen_lo_reg} == 16'd0)
                begin
                    do_adv = 1'b1;
                end else
                begin
                    phase_next = PH_EXTRA;
                end
            end
            PH_EXTRA, PH_HCRC:
            begin
                skip_next = skip_dec;
                do_adv    = (skip_dec == 16'd0);
            end
            PH_NAME, PH_COMMENT:
            begin
                do_adv = (data_byte == 8'h00);
            end
            default:
            begin
            end
        endcase

        adv = advance(adv_from, flags_next);
        if (do_adv)
        begin
            phase_next = adv.phase;
            if (adv.load_crc)
            begin
                skip_next = 16'd2;
            end
            if (adv.mark_end)
            begin
                hend_next = count_next;
            end
        end

        err_next = (err_reg != ST_OK) ? err_reg : err_new;
    end

    // status for a stream ending on this byte
    always_comb
    begin
        result.header_length = '0;
        if (count_next < FIXED_LEN)
        begin
            result.status = ST_SHORT;
        end else if (err_next != ST_OK)
        begin
            result.status = err_next;
        end else if (phase_next == PH_XLEN_LO || phase_next == PH_XLEN_HI)
        begin
            result.status = ST_XLEN_TRNC;
        end else if (phase_next != PH_DONE || hend_next >= count_next)
        begin
            result.status = ST_OVERRUN;
        end else
        begin
            result.status        = ST_OK;
            result.header_length = hend_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_FIXED;
            count_reg   <= '0;
            flags_reg   <= '0;
            skip_reg    <= '0;
            xlen_lo_reg <= '0;
            hend_reg    <= '0;
            err_reg     <= ST_OK;
        end else if (take)
        begin
            if (final_byte)
            begin
                phase_reg   <= PH_FIXED;
                count_reg   <= '0;
                flags_reg   <= '0;
                skip_reg    <= '0;
                xlen_lo_reg <= '0;
                hend_reg    <= '0;
                err_reg     <= ST_OK;
            end else
            begin
                phase_reg   <= phase_next;
                count_reg   <= count_next;
                flags_reg   <= flags_next;
                skip_reg    <= skip_next;
                xlen_lo_reg <= xlen_lo_next;
                hend_reg    <= hend_next;
                err_reg     <= err_next;
            end
        end
    end

endmodule

// ===== hdl/gzip_header_stripper_top.sv =====
// gzip header parser. Takes a gzip stream one byte per transfer on 'stream',
// with final_byte set on its last byte, and returns exactly one transfer on
// 'result' per stream, caused by that last byte: a status (0 ok, 1 under ten
// bytes, 2 bad magic or method, 3 reserved flag bits, 4 stream ended inside
// the extra-length field, 5 header reaches or passes the end of the stream)
// and, when ok, the offset of the first deflate byte. Optional extra, name,
// comment and header CRC fields are skipped; the CRC is not checked. Byte
// positions saturate at 65535. Each byte is parsed in the cycle it is taken,
// so the block takes one byte per clock; a result appears in the cycle after
// its final byte and sits in a single output register. stream.ready drops
// only while that register holds a result that result.ready has not taken,
// and the parser returns to its reset state right after each final byte.
module gzip_header_stripper_top
    import gzhs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    gzhs_byte_if.sink     stream,
    gzhs_result_if.source result
);

    logic         take;
    gzhs_result_t parse_res;

    logic         out_valid_reg;
    gzhs_result_t out_data_reg;

    // next byte may enter whenever the output slot is free or draining
    assign stream.ready = !out_valid_reg || result.ready;
    assign take         = stream.valid && stream.ready;

    gzhs_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .data_byte  (stream.data_byte),
        .final_byte (stream.final_byte),
        .result     (parse_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end else if (take && stream.final_byte)
        begin
            out_valid_reg <= 1'b1;
        end else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        if (take && stream.final_byte)
        begin
            out_data_reg <= parse_res;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.status        = out_data_reg.status;
    assign result.header_length = out_data_reg.header_length;

endmodule

// ===== hdl/gzhs_checker.sv =====
module gzhs_checker
    import gzhs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_final,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [15:0] header_length
);

    // a final byte always yields a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_final |=> out_valid)
        else $error("final byte gave no result");

    // a good header is at least the fixed part long
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK |-> header_length >= FIXED_LEN)
        else $error("ok result with short header length");

    // errors carry no length, and codes stay in range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> header_length == 16'd0 && status <= ST_OVERRUN)
        else $error("bad error result");

    // a pending result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(header_length))
        else $error("result changed while stalled");

endmodule

bind gzip_header_stripper_top gzhs_checker u_gzhs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (stream.valid),
    .in_ready      (stream.ready),
    .in_final      (stream.final_byte),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .status        (result.status),
    .header_length (result.header_length)
);

// ===== verif/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gzhs_pkg::*;

    // Run-wide knobs
    localparam int CYCLE_LIMIT  = 1_000_000; // far above the slowest legal run
    localparam int RANDOM_BYTES = 950;       // random streams stop after this many transfers
    localparam int HOLD_CYCLES  = 400;       // one long receiver stall
    localparam int DRAIN_CYCLES = 20;        // result shows up in the cycle after its final byte
    localparam int MAX_SHOWN    = 10;

    localparam gzhs_result_t NULL_REPORT = '0;

    // Parser stages, in the order the optional fields appear in a header
    typedef enum logic [3:0] {
        STG_FIXED,
        STG_XLEN_LO,
        STG_XLEN_HI,
        STG_EXTRA,
        STG_NAME,
        STG_COMMENT,
        STG_HCRC,
        STG_DONE
    } hdr_stage_t;

    // One row of the directed table. 'typed' rows carry their expected report
    // directly; the rest rely on the header model below.
    typedef struct packed {
        logic [7:0]   data;
        logic         last;
        logic         typed;
        gzhs_result_t report;
    } directed_row_t;

    logic clk;
    logic rst_n;

    gzhs_byte_if   stream_if ();
    gzhs_result_if result_if ();

    gzip_header_stripper_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_if),
        .result (result_if)
    );

    // Clock: 2 ns period
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Header model: tracks the stream exactly as the block should and
    // yields a report on the final byte.
    // ------------------------------------------------------------------
    hdr_stage_t  stage;
    logic [15:0] seen_count;   // saturating byte position
    logic [7:0]  flg_reg;      // FLG byte of the fixed header
    logic [15:0] skip_left;    // bytes left in extra field or header CRC
    logic [7:0]  xlen_low;
    logic [16:0] hdr_end;      // offset of first deflate byte
    logic [2:0]  first_err;    // earliest fixed-header error

    function automatic void clear_parser();
        stage      = STG_FIXED;
        seen_count = '0;
        flg_reg    = '0;
        skip_left  = '0;
        xlen_low   = '0;
        hdr_end    = '0;
        first_err  = ST_OK;
    endfunction

    // Move to the first optional field flagged after 'from', or finish the header.
    function automatic void next_field(input hdr_stage_t from);
        if (from < STG_XLEN_LO && (flg_reg & FL_EXTRA) != 0)
            stage = STG_XLEN_LO;
        else if (from < STG_NAME && (flg_reg & FL_NAME) != 0)
            stage = STG_NAME;
        else if (from < STG_COMMENT && (flg_reg & FL_COMMENT) != 0)
            stage = STG_COMMENT;
        else if (from < STG_HCRC && (flg_reg & FL_HCRC) != 0)
        begin
            stage     = STG_HCRC;
            skip_left = 16'd2;
        end
        else
        begin
            stage   = STG_DONE;
            hdr_end = {1'b0, seen_count};
        end
    endfunction

    function automatic void flag_error(input logic [2:0] code);
        if (first_err == ST_OK)
            first_err = code;
    endfunction

    // Returns 1 when the byte closes a stream; 'rep' then holds its report.
    function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                      output gzhs_result_t rep);
        logic [15:0] idx;
        idx = seen_count;
        rep = NULL_REPORT;
        if (seen_count != CNT_MAX)
            seen_count = seen_count + 16'd1;

        case (stage)
            STG_FIXED:
            begin
                if ((idx == 16'd0 && b != MAGIC_ID1) || (idx == 16'd1 && b != MAGIC_ID2) ||
                    (idx == 16'd2 && b != METHOD_DEFL))
                    flag_error(ST_MAGIC);
                if (idx == 16'd3)
                begin
                    flg_reg = b;
                    if ((b & FL_RESERVED) != 0)
                        flag_error(ST_RESERVED);
                end
                if ({1'b0, idx} + 17'd1 >= {1'b0, FIXED_LEN})
                    next_field(STG_FIXED);
            end
            STG_XLEN_LO:
            begin
                xlen_low = b;
                stage    = STG_XLEN_HI;
            end
            STG_XLEN_HI:
            begin
                skip_left = {b, xlen_low};
                if (skip_left == 16'd0)
                    next_field(STG_EXTRA);
                else
                    stage = STG_EXTRA;
            end
            STG_EXTRA, STG_HCRC:
            begin
                skip_left = skip_left - 16'd1;
                if (skip_left == 16'd0)
                    next_field(stage);
            end
            STG_NAME, STG_COMMENT:
            begin
                if (b == 8'h00)
                    next_field(stage);
            end
            default: ;
        endcase

        if (!last)
            return 1'b0;

        if (seen_count < FIXED_LEN)
            rep.status = ST_SHORT;
        else if (first_err != ST_OK)
            rep.status = first_err;
        else if (stage == STG_XLEN_LO || stage == STG_XLEN_HI)
            rep.status = ST_XLEN_TRNC;
        else if (stage != STG_DONE || hdr_end >= {1'b0, seen_count})
            rep.status = ST_OVERRUN;
        else
        begin
            rep.status        = ST_OK;
            rep.header_length = hdr_end[15:0];
        end
        clear_parser();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Shared state between the driver, the receiver and the monitor
    // ------------------------------------------------------------------
    gzhs_result_t reports_due[$];   // reports owed by the block, oldest first
    int           fail_count  = 0;
    int           bytes_sent  = 0;
    int           cycle_count = 0;
    int           src_idle_pct = 29;
    int           snk_idle_pct = 75;
    bit           hold_go = 1'b0;   // asks the receiver for its long stall

    // Report attached to the item on the bus (directed rows only)
    logic         row_typed;
    gzhs_result_t row_report;

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_SHOWN)
            $display("%s", msg);
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random ready, plus one long stall counted here
    // ------------------------------------------------------------------
    int hold_left = 0;
    bit hold_done = 1'b0;

    initial result_if.ready = 1'b0;

    always @(negedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_if.ready <= 1'b0;
        end
        else
            result_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: check result transfers first, then feed the model with the
    // byte taken at this edge. A report can never come out at the same
    // edge as its final byte, so this order is safe.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        gzhs_result_t owed;
        gzhs_result_t predicted;
        if (rst_n)
        begin
            if (result_if.valid && result_if.ready)
            begin
                if (reports_due.size() == 0)
                    note_failure($sformatf("unexpected result: status=%0d header_length=%0d",
                                           result_if.status, result_if.header_length));
                else
                begin
                    owed = reports_due.pop_front();
                    if (result_if.status !== owed.status)
                        note_failure($sformatf("status mismatch: expected %0d, got %0d",
                                               owed.status, result_if.status));
                    if (result_if.header_length !== owed.header_length)
                        note_failure($sformatf("header_length mismatch: expected %0d, got %0d",
                                               owed.header_length, result_if.header_length));
                end
            end
            if (stream_if.valid && stream_if.ready)
            begin
                if (parse_byte(stream_if.data_byte, stream_if.final_byte, predicted))
                    reports_due.push_back(row_typed ? row_report : predicted);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver. Every call starts and ends at a falling edge; valid is only
    // lowered when the sender actually idles, so back-to-back transfers
    // keep it high without a glitch.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last,
                             input logic typed, input gzhs_result_t rep);
        while ($urandom_range(99) < src_idle_pct)
        begin
            stream_if.valid <= 1'b0;
            @(negedge clk);
        end
        stream_if.valid      <= 1'b1;
        stream_if.data_byte  <= b;
        stream_if.final_byte <= last;
        row_typed            <= typed;
        row_report           <= rep;
        @(posedge clk);
        while (!stream_if.ready)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    // Random stream. Mostly well-formed headers with random flags and
    // field contents, some truncated or with a corrupted magic/method byte,
    // and a few streams of pure noise.
    logic [7:0] stream_bytes[$];

    task automatic build_stream();
        int          kind;
        int          keep;
        int          idx;
        logic [7:0]  flg;
        logic [15:0] xlen;
        stream_bytes.delete();
        kind = $urandom_range(99);
        if (kind < 10)
        begin
            repeat ($urandom_range(1, 14))
                stream_bytes.push_back(8'($urandom));
        end
        else
        begin
            flg = 8'($urandom_range(0, 31));
            if ($urandom_range(99) < 8)
                flg[7:5] = 3'($urandom_range(1, 7));
            stream_bytes.push_back(MAGIC_ID1);
            stream_bytes.push_back(MAGIC_ID2);
            stream_bytes.push_back(METHOD_DEFL);
            stream_bytes.push_back(flg);
            repeat (6)
                stream_bytes.push_back(8'($urandom));   // MTIME, XFL, OS
            if ($urandom_range(99) < 8)
            begin
                idx = $urandom_range(0, 2);
                stream_bytes[idx] = stream_bytes[idx] ^ 8'($urandom_range(1, 255));
            end
            if ((flg & FL_EXTRA) != 0)
            begin
                if ($urandom_range(99) < 15)
                    xlen = 16'd0;
                else if ($urandom_range(99) < 4)
                    xlen = 16'($urandom_range(256, 300));
                else
                    xlen = 16'($urandom_range(1, 6));
                stream_bytes.push_back(xlen[7:0]);
                stream_bytes.push_back(xlen[15:8]);
                repeat (xlen)
                    stream_bytes.push_back(8'($urandom));
            end
            if ((flg & FL_NAME) != 0)
            begin
                repeat ($urandom_range(0, 5))
                    stream_bytes.push_back(8'($urandom_range(1, 255)));
                stream_bytes.push_back(8'h00);
            end
            if ((flg & FL_COMMENT) != 0)
            begin
                repeat ($urandom_range(0, 5))
                    stream_bytes.push_back(8'($urandom_range(1, 255)));
                stream_bytes.push_back(8'h00);
            end
            if ((flg & FL_HCRC) != 0)
                repeat (2)
                    stream_bytes.push_back(8'($urandom));
            // zero deflate bytes means the header ends on the final byte
            repeat ($urandom_range(0, 4))
                stream_bytes.push_back(8'($urandom));
            if ($urandom_range(99) < 20)
            begin
                keep = $urandom_range(1, stream_bytes.size());
                while (stream_bytes.size() > keep)
                    void'(stream_bytes.pop_back());
            end
        end
    endtask

    // Directed rows: short streams, minimal valid header, bad first magic byte with
    // flag and later bytes at maximum (magic error wins over reserved flags).
    directed_row_t directed_rows [24] = '{
        '{8'hFF, 1'b1, 1'b1, '{ST_SHORT, 16'd0}},
        '{MAGIC_ID1, 1'b0, 1'b0, NULL_REPORT},
        '{MAGIC_ID2, 1'b1, 1'b1, '{ST_SHORT, 16'd0}},
        '{MAGIC_ID1, 1'b0, 1'b0, NULL_REPORT},
        '{MAGIC_ID2, 1'b0, 1'b0, NULL_REPORT},
        '{METHOD_DEFL, 1'b0, 1'b0, NULL_REPORT},
        '{8'h00, 1'b0, 1'b0, NULL_REPORT},
        '{8'h00, 1'b0, 1'b0, NULL_REPORT},
        '{8'h00, 1'b0, 1'b0, NULL_REPORT},
        '{8'h00, 1'b0, 1'b0, NULL_REPORT},
        '{8'h00, 1'b0, 1'b0, NULL_REPORT},
        '{8'h00, 1'b0, 1'b0, NULL_REPORT},
        '{8'hFF, 1'b0, 1'b0, NULL_REPORT},
        '{8'h00, 1'b1, 1'b1, '{ST_OK, 16'd10}},
        '{8'h00, 1'b0, 1'b0, NULL_REPORT},
        '{MAGIC_ID2, 1'b0, 1'b0, NULL_REPORT},
        '{METHOD_DEFL, 1'b0, 1'b0, NULL_REPORT},
        '{8'hFF, 1'b0, 1'b0, NULL_REPORT},
        '{8'hFF, 1'b0, 1'b0, NULL_REPORT},
        '{8'hFF, 1'b0, 1'b0, NULL_REPORT},
        '{8'hFF, 1'b0, 1'b0, NULL_REPORT},
        '{8'hFF, 1'b0, 1'b0, NULL_REPORT},
        '{8'hFF, 1'b0, 1'b0, NULL_REPORT},
        '{8'hFF, 1'b1, 1'b1, '{ST_MAGIC, 16'd0}}
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                = 1'b0;
        stream_if.valid      = 1'b0;
        stream_if.data_byte  = 8'h00;
        stream_if.final_byte = 1'b0;
        row_typed            = 1'b0;
        row_report           = NULL_REPORT;
        clear_parser();

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_byte(directed_rows[i].data, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].report);

        // Random streams in three idle settings: sender light/receiver heavy,
        // then swapped, then no random idling but one long receiver stall.
        while (bytes_sent < RANDOM_BYTES)
        begin
            if (bytes_sent < RANDOM_BYTES / 3)
            begin
                src_idle_pct = 29;
                snk_idle_pct = 75;
            end
            else if (bytes_sent < 2 * RANDOM_BYTES / 3)
            begin
                src_idle_pct = 75;
                snk_idle_pct = 29;
            end
            else
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
                hold_go      = 1'b1;   // receiver stalls while streams keep coming
            end
            build_stream();
            foreach (stream_bytes[i])
                send_byte(stream_bytes[i], i == stream_bytes.size() - 1, 1'b0, NULL_REPORT);
        end

        stream_if.valid <= 1'b0;

        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
